>>> src/vlu_pkg.sv
package vlu_pkg;

    // Default sizes of the block
    localparam int GRID_SIDE_MAX_DEF = 128;
    localparam int MAX_SPECIES_DEF   = 10;
    localparam int MAX_NEIGHBORS_DEF = 8;

    // Field widths of the request, result and configuration beats
    localparam int OP_W    = 2;
    localparam int COORD_W = 7;
    localparam int LABEL_W = 4;
    localparam int DIR_W   = 3;
    localparam int RND_W   = 16;
    localparam int CNT_W   = 4;
    localparam int NS_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_BAD    = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STATES    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBORS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSETS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE      = 3'd5;

    // Register reset values
    localparam logic        RST_MODE      = 1'b0;
    localparam logic [3:0]  RST_STATES    = 4'd2;
    localparam logic [3:0]  RST_NEIGHBORS = 4'd4;
    localparam logic [3:0]  RST_THRESHOLD = 4'd2;
    localparam logic [31:0] RST_OFFSETS   = 32'd2113258545;
    localparam logic [7:0]  RST_SIDE      = 8'd128;

endpackage

>>> src/vlu_ifs.sv
// Request channel: one operation on the grid
interface vlu_item_if;
    logic                            valid;
    logic                            ready;
    logic [vlu_pkg::OP_W-1:0]        operation;
    logic [vlu_pkg::COORD_W-1:0]     col_x;
    logic [vlu_pkg::COORD_W-1:0]     row_y;
    logic [vlu_pkg::LABEL_W-1:0]     load_value;
    logic [vlu_pkg::DIR_W-1:0]       direction;
    logic [vlu_pkg::RND_W-1:0]       random_pick;

    modport source (output valid, operation, col_x, row_y, load_value, direction,
                    random_pick, input ready);
    modport sink   (input valid, operation, col_x, row_y, load_value, direction,
                    random_pick, output ready);
endinterface

// Result channel: one beat per request
interface vlu_result_if;
    logic                            valid;
    logic                            ready;
    logic [vlu_pkg::LABEL_W-1:0]     cell_state;
    logic                            changed;
    logic                            no_candidate;
    logic                            bad_request;

    modport source (output valid, cell_state, changed, no_candidate, bad_request,
                    input ready);
    modport sink   (input valid, cell_state, changed, no_candidate, bad_request,
                    output ready);
endinterface

// Register write channel
interface vlu_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [vlu_pkg::CFG_IDX_W-1:0]     index;
    logic [vlu_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/vlu_ram.sv
// Single-port RAM, registered read (read-first)
module vlu_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/voter_lattice_update_core.sv
// Channel    Dir  Beat contents
// i_item     in   operation, col_x, row_y, load_value, direction, random_pick
// o_result   out  cell_state, changed, no_candidate, bad_request
// i_cfg      in   register index, write data (always ready)
//
// Load and read: check, site address and data, result. A linear update puts
// neighbor address and data before the site steps; a threshold update puts
// address and data per neighbor, mark, the remainder unit (one bit a cycle)
// and a scan of up to MAX_SPECIES species, skipping unit and scan if none
// qualifies. Bad requests: check, result. One request is in work at a time;
// i_item.ready is high only when idle. Reset is synchronous, active low; it
// resets the configuration, the sequencer and result valid, the grid holds
// garbage until loaded. A stalled result holds the sequencer in its final
// step; the grid write happens in the cycle the result is registered.
module voter_lattice_update_core #(
    parameter int GRID_SIDE_MAX = vlu_pkg::GRID_SIDE_MAX_DEF,
    parameter int MAX_SPECIES   = vlu_pkg::MAX_SPECIES_DEF,
    parameter int MAX_NEIGHBORS = vlu_pkg::MAX_NEIGHBORS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    vlu_item_if.sink       i_item,
    vlu_result_if.source   o_result,
    vlu_cfg_if.sink        i_cfg
);

    localparam int DEPTH    = GRID_SIDE_MAX * GRID_SIDE_MAX;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int SIDE_W   = $clog2(GRID_SIDE_MAX + 1);
    localparam int CRD_W    = ($clog2(GRID_SIDE_MAX) > vlu_pkg::COORD_W) ?
                              $clog2(GRID_SIDE_MAX) : vlu_pkg::COORD_W;
    localparam int CMP_W    = (SIDE_W > 8) ? SIDE_W : 8;
    localparam int TW       = ((SIDE_W > CRD_W) ? SIDE_W : CRD_W) + 1;
    localparam int SP_IDX_W = $clog2(MAX_SPECIES);
    localparam int BIT_W    = $clog2(vlu_pkg::RND_W);
    localparam int NS_W     = vlu_pkg::NS_W;
    localparam int LABEL_W  = vlu_pkg::LABEL_W;
    localparam int CNT_W    = vlu_pkg::CNT_W;
    localparam int RND_W    = vlu_pkg::RND_W;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_NADDR, S_NDATA, S_MARK,
        S_DIV, S_SCAN, S_SITE, S_SDATA, S_FIN
    } t_state;

    t_state r_state;

    // Configuration registers
    logic        r_mode;
    logic [3:0]  r_ns;
    logic [3:0]  r_nn;
    logic [3:0]  r_thr;
    logic [31:0] r_offs;
    logic [7:0]  r_side;

    // Request registers
    logic [vlu_pkg::OP_W-1:0]    r_op;
    logic [vlu_pkg::COORD_W-1:0] r_x;
    logic [vlu_pkg::COORD_W-1:0] r_y;
    logic [LABEL_W-1:0]          r_lv;
    logic [vlu_pkg::DIR_W-1:0]   r_dir;
    logic [RND_W-1:0]            r_rnd;

    // Work registers
    logic [vlu_pkg::DIR_W-1:0]   r_dcnt;
    logic [CNT_W-1:0]            r_cnt [MAX_SPECIES];
    logic [MAX_SPECIES-1:0]      r_mark;
    logic [NS_W-1:0]             r_div;
    logic [NS_W-1:0]             r_rem;
    logic [BIT_W-1:0]            r_bit;
    logic [SP_IDX_W-1:0]         r_sidx;
    logic [LABEL_W-1:0]          r_now;
    logic [LABEL_W-1:0]          r_old;
    logic                        r_bad;
    logic                        r_nocand;

    // Result register
    logic                        r_out_valid;
    logic [LABEL_W-1:0]          r_out_state;
    logic                        r_out_changed;
    logic                        r_out_nocand;
    logic                        r_out_bad;

    // Effective (saturated) configuration
    logic [SIDE_W-1:0] side_eff;
    logic [NS_W-1:0]   ns_eff;
    logic [3:0]        nn_eff;
    logic [CMP_W-1:0]  side_raw;

    assign side_raw = CMP_W'(r_side);
    assign side_eff = (side_raw < CMP_W'(2)) ? SIDE_W'(2) :
                      (side_raw > CMP_W'(GRID_SIDE_MAX)) ? SIDE_W'(GRID_SIDE_MAX) :
                      SIDE_W'(side_raw);
    assign ns_eff   = ({1'b0, r_ns} < NS_W'(2)) ? NS_W'(2) :
                      ({1'b0, r_ns} > NS_W'(MAX_SPECIES)) ? NS_W'(MAX_SPECIES) :
                      {1'b0, r_ns};
    assign nn_eff   = (r_nn == 4'd0) ? 4'd1 :
                      (r_nn > 4'(MAX_NEIGHBORS)) ? 4'(MAX_NEIGHBORS) : r_nn;

    // Torus step: coordinate plus a 2-bit signed offset, one fold back
    function automatic logic [CRD_W-1:0] wrap_step(input logic [CRD_W-1:0] c,
                                                   input logic [1:0] d,
                                                   input logic [SIDE_W-1:0] s);
        logic [TW-1:0] t;
        logic [TW-1:0] sw;
        sw = TW'(s);
        if (d[1]) begin
            t = TW'(c) + sw - TW'(3'd4 - {1'b0, d});
        end else begin
            t = TW'(c) + TW'(d);
        end
        if (t >= sw) begin
            t = t - sw;
        end
        return CRD_W'(t);
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [CRD_W-1:0] x,
                                                  input logic [CRD_W-1:0] y);
        return ADDR_W'(32'(y) * 32'(GRID_SIDE_MAX) + 32'(x));
    endfunction

    // Request check
    logic req_bad;
    assign req_bad = (r_op == vlu_pkg::OP_BAD) ||
                     (CMP_W'(r_x) >= CMP_W'(side_eff)) ||
                     (CMP_W'(r_y) >= CMP_W'(side_eff)) ||
                     ((r_op == vlu_pkg::OP_UPDATE) && !r_mode &&
                      ({1'b0, r_dir} >= nn_eff));

    // Neighbor address for the current direction
    logic [vlu_pkg::DIR_W-1:0] cur_dir;
    logic [3:0]                nib;
    logic [CRD_W-1:0]          nx;
    logic [CRD_W-1:0]          ny;
    logic [ADDR_W-1:0]         nbr_addr;
    logic [ADDR_W-1:0]         site_addr;

    assign cur_dir   = r_mode ? r_dcnt : r_dir;
    assign nib       = r_offs[cur_dir*4 +: 4];
    assign nx        = wrap_step(CRD_W'(r_x), nib[1:0], side_eff);
    assign ny        = wrap_step(CRD_W'(r_y), nib[3:2], side_eff);
    assign nbr_addr  = addr_of(nx, ny);
    assign site_addr = addr_of(CRD_W'(r_x), CRD_W'(r_y));

    // Grid memory
    logic               out_free;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [LABEL_W-1:0] ram_rdata;

    assign out_free = !r_out_valid || o_result.ready;
    assign ram_we   = (r_state == S_FIN) && out_free && !r_bad && (r_op != vlu_pkg::OP_READ);
    assign ram_addr = (r_state == S_NADDR) ? nbr_addr : site_addr;

    vlu_ram #(
        .WIDTH (LABEL_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_now),
        .o_rdata (ram_rdata)
    );

    // Species marks and their count
    logic [MAX_SPECIES-1:0] mark;
    logic [NS_W-1:0]        marked;

    always_comb begin
        for (int s = 0; s < MAX_SPECIES; s++) begin
            mark[s] = (NS_W'(s) < ns_eff) && (r_cnt[s] >= r_thr);
        end
    end
    assign marked = NS_W'($countones(mark));

    // Remainder step: shift in one bit of the random word, subtract if it fits
    logic [NS_W:0]   rem_sh;
    logic [NS_W-1:0] div_rem;

    assign rem_sh  = {r_rem, r_rnd[RND_W-1]};
    assign div_rem = (rem_sh >= {1'b0, r_div}) ? NS_W'(rem_sh - {1'b0, r_div}) :
                                                 NS_W'(rem_sh);

    // Load clamp
    logic [LABEL_W-1:0] ns_top;
    logic [LABEL_W-1:0] load_clamped;

    assign ns_top       = LABEL_W'(ns_eff - NS_W'(1));
    assign load_clamped = (r_lv > ns_top) ? ns_top : r_lv;

    // Handshakes
    assign i_item.ready          = (r_state == S_IDLE);
    assign i_cfg.ready           = 1'b1;
    assign o_result.valid        = r_out_valid;
    assign o_result.cell_state   = r_out_state;
    assign o_result.changed      = r_out_changed;
    assign o_result.no_candidate = r_out_nocand;
    assign o_result.bad_request  = r_out_bad;

    // Sequencer, configuration and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mode      <= vlu_pkg::RST_MODE;
            r_ns        <= vlu_pkg::RST_STATES;
            r_nn        <= vlu_pkg::RST_NEIGHBORS;
            r_thr       <= vlu_pkg::RST_THRESHOLD;
            r_offs      <= vlu_pkg::RST_OFFSETS;
            r_side      <= vlu_pkg::RST_SIDE;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    vlu_pkg::REG_MODE:      r_mode <= i_cfg.data[0];
                    vlu_pkg::REG_STATES:    r_ns   <= i_cfg.data[3:0];
                    vlu_pkg::REG_NEIGHBORS: r_nn   <= i_cfg.data[3:0];
                    vlu_pkg::REG_THRESHOLD: r_thr  <= i_cfg.data[3:0];
                    vlu_pkg::REG_OFFSETS:   r_offs <= i_cfg.data;
                    vlu_pkg::REG_SIDE:      r_side <= i_cfg.data[7:0];
                    default: ;
                endcase
            end

            // drain the result; S_FIN reloads it on its own
            if (r_out_valid && o_result.ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_op    <= i_item.operation;
                        r_x     <= i_item.col_x;
                        r_y     <= i_item.row_y;
                        r_lv    <= i_item.load_value;
                        r_dir   <= i_item.direction;
                        r_rnd   <= i_item.random_pick;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_nocand <= 1'b0;
                    if (req_bad) begin
                        r_bad   <= 1'b1;
                        r_now   <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_bad <= 1'b0;
                        if (r_op == vlu_pkg::OP_UPDATE) begin
                            r_dcnt <= '0;
                            for (int s = 0; s < MAX_SPECIES; s++) begin
                                r_cnt[s] <= '0;
                            end
                            r_state <= S_NADDR;
                        end else begin
                            r_state <= S_SITE;
                        end
                    end
                end
                S_NADDR: begin
                    r_state <= S_NDATA;
                end
                S_NDATA: begin
                    if (!r_mode) begin
                        r_now   <= ram_rdata;
                        r_state <= S_SITE;
                    end else begin
                        // tally the label if it is a species in use
                        for (int s = 0; s < MAX_SPECIES; s++) begin
                            if ((ram_rdata == LABEL_W'(s)) && ({1'b0, ram_rdata} < ns_eff)) begin
                                r_cnt[s] <= r_cnt[s] + CNT_W'(1);
                            end
                        end
                        if (r_dcnt == vlu_pkg::DIR_W'(nn_eff - 4'd1)) begin
                            r_state <= S_MARK;
                        end else begin
                            r_dcnt  <= r_dcnt + vlu_pkg::DIR_W'(1);
                            r_state <= S_NADDR;
                        end
                    end
                end
                S_MARK: begin
                    r_mark <= mark;
                    if (marked == '0) begin
                        r_nocand <= 1'b1;
                        r_state  <= S_SITE;
                    end else begin
                        r_div   <= marked;
                        r_rem   <= '0;
                        r_bit   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= div_rem;
                    r_rnd <= r_rnd << 1;
                    r_bit <= r_bit + BIT_W'(1);
                    if (r_bit == BIT_W'(RND_W - 1)) begin
                        r_sidx  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // skip r_rem marked species, take the next one
                    if (r_mark[r_sidx]) begin
                        if (r_rem == '0) begin
                            r_now   <= LABEL_W'(r_sidx);
                            r_state <= S_SITE;
                        end else begin
                            r_rem <= r_rem - NS_W'(1);
                        end
                    end
                    r_sidx <= r_sidx + SP_IDX_W'(1);
                end
                S_SITE: begin
                    r_state <= S_SDATA;
                end
                S_SDATA: begin
                    r_old <= ram_rdata;
                    case (r_op)
                        vlu_pkg::OP_LOAD: r_now <= load_clamped;
                        vlu_pkg::OP_READ: r_now <= ram_rdata;
                        default: begin
                            if (r_nocand) begin
                                r_now <= ram_rdata;
                            end
                        end
                    endcase
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_state   <= r_now;
                        r_out_changed <= !r_bad && (r_op != vlu_pkg::OP_READ) &&
                                         (r_now != r_old);
                        r_out_nocand  <= r_nocand;
                        r_out_bad     <= r_bad;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A refused request reports nothing else
    a_bad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bad) |-> (r_out_state == '0 && !r_out_changed && !r_out_nocand))
        else $error("bad result carries data");

    // No candidate means the site kept its label
    a_nocand_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_nocand) |-> !r_out_changed)
        else $error("no-candidate result reports a change");

    // Remainder stays below the divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) || (r_state == S_SCAN)) |-> (r_rem < r_div))
        else $error("remainder out of range");

    // The scan finds its species before running off the species in use
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (NS_W'(r_sidx) < ns_eff))
        else $error("species scan overran");

    // The grid is written only when a result is registered
    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_out_valid && !r_out_bad))
        else $error("grid write without result");

endmodule
